// ----- rtl/csr_register_file_rw_assert.svh -----
// Assertion macros shared by the CSR register file modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef CSR_REGISTER_FILE_RW_ASSERT_SVH
`define CSR_REGISTER_FILE_RW_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CRF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/crf_pkg.sv -----
// Shared types and constants of the CSR register file.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package crf_pkg;

    localparam int unsigned ADDR_BITS  = 12;
    localparam int unsigned DEPTH      = 1 << ADDR_BITS;
    localparam int unsigned CSR_ADDR_W = 12;
    localparam int unsigned XLEN       = 64;

    typedef logic [CSR_ADDR_W-1:0] csr_addr_t;
    typedef logic [ADDR_BITS-1:0]  idx_t;
    typedef logic [XLEN-1:0]       xword_t;

    typedef enum logic
    {
        FUNC_SWAP = 1'b0,
        FUNC_SET  = 1'b1
    } func_t;

    // Standard CSR addresses that have a view of their own.
    localparam csr_addr_t CSR_SSTATUS    = 12'h100;
    localparam csr_addr_t CSR_SIE        = 12'h104;
    localparam csr_addr_t CSR_SIP        = 12'h144;
    localparam csr_addr_t CSR_MSTATUS    = 12'h300;
    localparam csr_addr_t CSR_MEDELEG    = 12'h302;
    localparam csr_addr_t CSR_MIDELEG    = 12'h303;
    localparam csr_addr_t CSR_MIE        = 12'h304;
    localparam csr_addr_t CSR_MCOUNTEREN = 12'h306;
    localparam csr_addr_t CSR_MENVCFG    = 12'h30A;
    localparam csr_addr_t CSR_MIP        = 12'h344;

    // Read and write masks of the views.
    localparam xword_t MASK_MSTATUS_W = 64'h8000_0000_ffff_ffff;
    localparam xword_t MASK_SSTATUS_R = 64'h8000_0003_000d_e762;
    localparam xword_t MASK_SSTATUS_W = 64'h8000_0000_000d_e762;
    localparam xword_t MASK_MEDELEG_W = 64'h0000_0000_000f_b3ff;
    localparam xword_t MASK_MIDELEG_W = 64'h0000_0000_0000_0222;
    localparam xword_t MASK_IP_W      = 64'h0000_0000_0000_0026;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic clear;    // write zero at the sweep counter
        logic capture;  // latch the request and read the store
        logic commit;   // write back and load the result register
    } crf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic clear_last; // sweep counter is at the last entry
    } crf_sts_t;

endpackage

`default_nettype wire

// ----- rtl/crf_if.sv -----
// Valid/ready channel interfaces for CSR requests and responses.
// Depends on crf_pkg for the payload types.
`default_nettype none

interface crf_req_if
    import crf_pkg::*;
;
    logic      valid;
    logic      ready;
    logic      func;
    csr_addr_t csr_addr;
    xword_t    source_value;

    modport source (output valid, output func, output csr_addr, output source_value,
                    input ready);
    modport sink   (input valid, input func, input csr_addr, input source_value,
                    output ready);
endinterface

interface crf_rsp_if
    import crf_pkg::*;
;
    logic   valid;
    logic   ready;
    xword_t old_value;

    modport source (output valid, output old_value, input ready);
    modport sink   (input valid, input old_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/crf_ctrl.sv -----
// Controller of the CSR register file: clearing sweep, capture and commit sequencing.
// Depends on crf_pkg and the assertion macro header.
`default_nettype none
`include "csr_register_file_rw_assert.svh"

module crf_ctrl
    import crf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output crf_cmd_t      cmd,
    input  wire crf_sts_t sts
);

    typedef enum logic [2:0]
    {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result slot must be free, or be emptied in this cycle.
                cmd.commit = !out_valid_reg || out_ready;
                if (cmd.commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `CRF_ASSERT_NXT(a_capture_enters_exec, clk, rst_n, cmd.capture, state_reg == ST_EXEC, "captured request did not reach execute")
    `CRF_ASSERT_NXT(a_commit_gives_result, clk, rst_n, cmd.commit, out_valid_reg, "commit did not present a result")
    `CRF_ASSERT_NXT(a_stall_holds_exec, clk, rst_n, (state_reg == ST_EXEC) && out_valid_reg && !out_ready, state_reg == ST_EXEC, "stalled request left execute")
    `CRF_ASSERT_IMP(a_quiet_while_clearing, clk, rst_n, state_reg == ST_CLEAR, !in_ready && !out_valid_reg, "channel active during clearing sweep")

endmodule

`default_nettype wire

// ----- rtl/crf_datapath.sv -----
// Datapath of the CSR register file: store memory, view decode and result register.
// Depends on crf_pkg.
`default_nettype none

module crf_datapath
    import crf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire crf_cmd_t  cmd,
    output crf_sts_t       sts,
    input  wire logic      func,
    input  wire csr_addr_t csr_addr,
    input  wire xword_t    source_value,
    output xword_t         old_value
);

    xword_t    mem [DEPTH];

    idx_t      clr_cnt_reg;
    idx_t      clr_cnt_next;
    csr_addr_t tgt_addr;
    idx_t      tgt_idx_reg;
    csr_addr_t addr_reg;
    logic      func_reg;
    xword_t    src_reg;
    xword_t    tgt_data_reg;
    xword_t    mideleg_data_reg;
    xword_t    old_value_reg;

    xword_t    view_old;
    xword_t    wr_value;
    xword_t    wr_data;
    logic      mem_we;
    idx_t      mem_widx;
    xword_t    mem_wdata;

    function automatic xword_t merge(input xword_t cur, input xword_t val, input xword_t mask);
        return (cur & ~mask) | (val & mask);
    endfunction

    // Supervisor views act on the entry of their machine counterpart.
    always_comb
    begin
        unique case (csr_addr)
            CSR_SSTATUS: tgt_addr = CSR_MSTATUS;
            CSR_SIE:     tgt_addr = CSR_MIE;
            CSR_SIP:     tgt_addr = CSR_MIP;
            default:     tgt_addr = csr_addr;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tgt_data_reg     <= mem[tgt_addr[ADDR_BITS-1:0]];
            mideleg_data_reg <= mem[CSR_MIDELEG[ADDR_BITS-1:0]];
            tgt_idx_reg      <= tgt_addr[ADDR_BITS-1:0];
            addr_reg         <= csr_addr;
            func_reg         <= func;
            src_reg          <= source_value;
        end
    end

    always_comb
    begin
        unique case (addr_reg) inside
            CSR_SSTATUS:              view_old = tgt_data_reg & MASK_SSTATUS_R;
            CSR_SIE, CSR_SIP:         view_old = tgt_data_reg & mideleg_data_reg;
            CSR_MENVCFG, CSR_MCOUNTEREN: view_old = '0;
            default:                  view_old = tgt_data_reg;
        endcase
    end

    assign wr_value = (func_reg == FUNC_SET) ? (view_old | src_reg) : src_reg;

    always_comb
    begin
        unique case (addr_reg) inside
            CSR_MSTATUS: wr_data = merge(tgt_data_reg, wr_value, MASK_MSTATUS_W);
            CSR_SSTATUS: wr_data = merge(tgt_data_reg, wr_value, MASK_SSTATUS_W);
            CSR_MEDELEG: wr_data = wr_value & MASK_MEDELEG_W;
            CSR_MIDELEG: wr_data = wr_value & MASK_MIDELEG_W;
            CSR_SIP:     wr_data = merge(tgt_data_reg, wr_value, mideleg_data_reg & MASK_IP_W);
            CSR_MIP:     wr_data = merge(tgt_data_reg, wr_value, MASK_IP_W);
            CSR_SIE:     wr_data = merge(tgt_data_reg, wr_value, mideleg_data_reg);
            CSR_MENVCFG, CSR_MCOUNTEREN: wr_data = '0;
            default:     wr_data = wr_value;
        endcase
    end

    assign mem_we    = cmd.clear || cmd.commit;
    assign mem_widx  = cmd.clear ? clr_cnt_reg : tgt_idx_reg;
    assign mem_wdata = cmd.clear ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_widx] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            old_value_reg <= view_old;
        end
    end

    assign clr_cnt_next = cmd.clear ? (clr_cnt_reg + 1'b1) : clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign sts.clear_last = &clr_cnt_reg;
    assign old_value      = old_value_reg;

endmodule

`default_nettype wire

// ----- rtl/csr_register_file_rw.sv -----
// Top level of the CSR register file: joins the controller and the datapath.
// Depends on crf_pkg, crf_if, crf_ctrl and crf_datapath.
//
//   Channel | Direction | Payload                             | Meaning
//   --------+-----------+-------------------------------------+------------------------------
//   req     | in        | func, csr_addr[11:0], source_value  | one CSR swap or set-bits
//   rsp     | out       | old_value[63:0]                     | value seen before the write
//
// Each request is the read-modify-write of one store entry: the transfer cycle reads the
// target entry and mideleg into registers, and the execute state forms the views, writes
// the entry back and loads the result register, which then drives rsp.
// After reset the store is swept to zero, one entry a cycle, over all 2^ADDR_BITS (4096)
// entries, while req.ready stays low.
// A waiting result stalls only the write-back of the next request until rsp takes it.
`default_nettype none

module csr_register_file_rw
    import crf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    crf_req_if.sink   req,
    crf_rsp_if.source rsp
);

    // Command and status bundles between the controller and the datapath.
    crf_cmd_t cmd;
    crf_sts_t sts;

    // The controller owns the handshakes and the sequence of each request.
    crf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the store, decodes the CSR views and keeps the result.
    crf_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .func         (req.func),
        .csr_addr     (req.csr_addr),
        .source_value (req.source_value),
        .old_value    (rsp.old_value)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for csr_register_file_rw: swap and set-bits CSR transfers
// checked against a behavioural model of the views, masks and delegation aliasing.
// Depends on crf_pkg, crf_if and the csr_register_file_rw RTL.
`default_nettype none

module tb;
    import crf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One CSR instruction as it is queued for the request driver.
    typedef struct packed
    {
        func_t     op;
        csr_addr_t addr;
        xword_t    src;
    } csr_req_t;

    // Addresses that have a view of their own. The random part leans on these.
    localparam int unsigned N_VIEWS = 10;
    localparam csr_addr_t VIEW_ADDRS [N_VIEWS] = '{
        CSR_SSTATUS, CSR_SIE, CSR_SIP, CSR_MSTATUS, CSR_MEDELEG,
        CSR_MIDELEG, CSR_MIE, CSR_MCOUNTEREN, CSR_MENVCFG, CSR_MIP
    };
    localparam int unsigned N_RANDOM   = 700;
    // Once this few requests remain, both sides stop idling.
    localparam int unsigned CALM_TAIL  = 120;

    logic clk;
    logic rst_n;

    crf_req_if req_ch ();
    crf_rsp_if rsp_ch ();

    csr_register_file_rw DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // The model's own image of the store, cleared as the block clears it after reset.
    xword_t   csr_image [DEPTH] = '{default: '0};
    csr_req_t pending_reqs [$];
    xword_t   old_value_q [$];

    int unsigned total_reqs;
    int unsigned accepted_reqs;
    int unsigned error_count;
    int unsigned req_gap;
    int unsigned rsp_stall;
    bit          req_taken;

    // A 10 ns clock, and reset held low at the start of the run only.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Every input of the block is at a known value from time zero.
    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.func         = FUNC_SWAP;
        req_ch.csr_addr     = '0;
        req_ch.source_value = '0;
        rsp_ch.ready        = 1'b0;
    end

    // Merge the masked bits of a value into the entry that an address selects.
    function automatic void merge_into(csr_addr_t target, xword_t value, xword_t mask);
        csr_image[idx_t'(target)] = (csr_image[idx_t'(target)] & ~mask) | (value & mask);
    endfunction

    // Execute one CSR instruction on the model image and return the old value that
    // the read view shows. The supervisor views are decoded on the full address and
    // land on their machine-level entries; mideleg is sampled before any write.
    function automatic xword_t csr_execute(func_t op, csr_addr_t addr, xword_t src);
        xword_t prior;
        xword_t wdata;
        xword_t deleg;
        deleg = csr_image[idx_t'(CSR_MIDELEG)];
        case (addr)
            CSR_SSTATUS:                 prior = csr_image[idx_t'(CSR_MSTATUS)] & MASK_SSTATUS_R;
            CSR_SIE:                     prior = csr_image[idx_t'(CSR_MIE)] & deleg;
            CSR_SIP:                     prior = csr_image[idx_t'(CSR_MIP)] & deleg;
            CSR_MENVCFG, CSR_MCOUNTEREN: prior = '0;
            default:                     prior = csr_image[idx_t'(addr)];
        endcase
        // A set-bits writes even when the source is zero, so the write masks still apply.
        wdata = (op == FUNC_SET) ? (prior | src) : src;
        case (addr)
            CSR_MSTATUS:                 merge_into(CSR_MSTATUS, wdata, MASK_MSTATUS_W);
            CSR_SSTATUS:                 merge_into(CSR_MSTATUS, wdata, MASK_SSTATUS_W);
            CSR_MEDELEG:                 csr_image[idx_t'(addr)] = wdata & MASK_MEDELEG_W;
            CSR_MIDELEG:                 csr_image[idx_t'(addr)] = wdata & MASK_MIDELEG_W;
            CSR_SIP:                     merge_into(CSR_MIP, wdata, deleg & MASK_IP_W);
            CSR_MIP:                     merge_into(CSR_MIP, wdata, MASK_IP_W);
            CSR_SIE:                     merge_into(CSR_MIE, wdata, deleg);
            CSR_MENVCFG, CSR_MCOUNTEREN: csr_image[idx_t'(addr)] = '0;
            default:                     csr_image[idx_t'(addr)] = wdata;
        endcase
        return prior;
    endfunction

    task automatic note_mismatch(string what, xword_t got, xword_t want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic queue_req(func_t op, csr_addr_t addr, xword_t src);
        csr_req_t item;
        item.op   = op;
        item.addr = addr;
        item.src  = src;
        pending_reqs.push_back(item);
        total_reqs++;
    endtask

    function automatic xword_t random_source();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            return '0;
        end
        if (pick == 1)
        begin
            return '1;
        end
        return {$urandom(), $urandom()};
    endfunction

    // Idling is switched off for a stretch in the middle and for the tail of the run.
    function automatic bit idling_allowed();
        return !((pending_reqs.size() < CALM_TAIL) ||
                 (pending_reqs.size() > 350 && pending_reqs.size() < 420));
    endfunction

    // Monitor: everything is sampled at the rising edge. A result transfer is checked
    // against the oldest expectation; a request transfer runs the model and queues
    // the old value it predicts. The result of a request can never come back in the
    // same cycle, so checking first and predicting second keeps the order right.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (old_value_q.size() == 0)
                begin
                    note_mismatch("unexpected result transfer, old_value", rsp_ch.old_value,
                                  '0);
                end
                else
                begin
                    xword_t want;
                    want = old_value_q.pop_front();
                    if (rsp_ch.old_value !== want)
                    begin
                        note_mismatch("old_value", rsp_ch.old_value, want);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                old_value_q.push_back(csr_execute(func_t'(req_ch.func), req_ch.csr_addr,
                                                  req_ch.source_value));
                accepted_reqs++;
                req_taken = 1'b1;
            end
        end
    end

    // Request driver: changes its outputs at the falling edge only. A request that has
    // not yet been taken is held; otherwise the next one goes out, unless a random gap
    // of idle cycles is running or is started here.
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            req_taken = 1'b0;
            if (req_gap > 0)
            begin
                req_ch.valid <= 1'b0;
                req_gap--;
            end
            else if (pending_reqs.size() == 0)
            begin
                req_ch.valid <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 5) == 0)
            begin
                req_ch.valid <= 1'b0;
                req_gap = $urandom_range(1, 12) - 1;
            end
            else
            begin
                csr_req_t item;
                item = pending_reqs.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.func         <= item.op;
                req_ch.csr_addr     <= item.addr;
                req_ch.source_value <= item.src;
            end
        end
    end

    // Result side back-pressure: ready drops for bursts of random length.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall--;
            end
            else if (idling_allowed() && $urandom_range(0, 6) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                rsp_stall = $urandom_range(1, 12) - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        xword_t pattern;
        pattern = 64'h5555_5555_5555_5555;

        // Directed part. mstatus through its own view and through sstatus, with all
        // bits set and cleared; a set-bits with a zero source still writes.
        queue_req(FUNC_SWAP, CSR_MSTATUS, '1);
        queue_req(FUNC_SET,  CSR_SSTATUS, '0);
        queue_req(FUNC_SWAP, CSR_SSTATUS, '0);
        queue_req(FUNC_SET,  CSR_MSTATUS, '0);
        // Delegation registers keep only their writable bits.
        queue_req(FUNC_SWAP, CSR_MEDELEG, '1);
        queue_req(FUNC_SET,  CSR_MEDELEG, '0);
        queue_req(FUNC_SWAP, CSR_MIDELEG, '1);
        // sie and sip alias mie and mip through mideleg.
        queue_req(FUNC_SWAP, CSR_MIE,     '1);
        queue_req(FUNC_SWAP, CSR_SIE,     '0);
        queue_req(FUNC_SET,  CSR_MIE,     '0);
        queue_req(FUNC_SWAP, CSR_MIP,     '1);
        queue_req(FUNC_SWAP, CSR_SIP,     '0);
        queue_req(FUNC_SET,  CSR_SIP,     '1);
        // With nothing delegated the supervisor views read zero and write nothing.
        queue_req(FUNC_SWAP, CSR_MIDELEG, '0);
        queue_req(FUNC_SET,  CSR_SIE,     '1);
        queue_req(FUNC_SWAP, CSR_MIE,     '0);
        // The hard-wired zero registers.
        queue_req(FUNC_SWAP, CSR_MENVCFG,    '1);
        queue_req(FUNC_SET,  CSR_MENVCFG,    '1);
        queue_req(FUNC_SWAP, CSR_MCOUNTEREN, '1);
        queue_req(FUNC_SET,  CSR_MCOUNTEREN, '0);
        // Plain registers at both ends of the address range.
        queue_req(FUNC_SWAP, 12'h000, '1);
        queue_req(FUNC_SWAP, 12'h000, pattern);
        queue_req(FUNC_SWAP, 12'hFFF, pattern);
        queue_req(FUNC_SET,  12'hFFF, ~pattern);
        queue_req(FUNC_SET,  12'hFFF, '0);

        // Random part: most requests hit the views, the rest spread over all addresses.
        repeat (N_RANDOM)
        begin
            csr_addr_t addr;
            if ($urandom_range(0, 9) < 6)
            begin
                addr = VIEW_ADDRS[$urandom_range(0, N_VIEWS - 1)];
            end
            else
            begin
                addr = csr_addr_t'($urandom_range(0, 4095));
            end
            queue_req(func_t'($urandom_range(0, 1)), addr, random_source());
        end

        // Wait at the falling edge, when every update of the rising edge has settled.
        @(posedge rst_n);
        while (accepted_reqs < total_reqs || old_value_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);

        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: the clearing sweep plus every request at its worst gaps and stalls
    // comes to well under half a millisecond.
    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
